// File: rtl/assert_macros.svh
// Assertion helpers for the checker file.
// TBP_ASSERT expects clk and arst_n, and TBP_ASSERT_NR expects clk, to be visible where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define TBP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TBP_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tbp_pkg: shared types and constants of the tournament branch predictor
// Opcode and state codes, counter limits, start values and the saturating
// two-bit counter update.
// ---------------------------------------------------------------------------
package tbp_pkg;

	typedef enum logic {
		OP_PREDICT = 1'b0,
		OP_TRAIN   = 1'b1
	} tbp_op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_FETCH,
		ST_INDEX,
		ST_RESOLVE
	} tbp_state_t;

	typedef struct packed {
		logic prediction;
		logic local_guess;
		logic global_guess;
		logic chose_global;
	} tbp_result_t;

	localparam logic [1:0] CTR_MAX = 2'd3;
	localparam logic [1:0] CTR_MIN = 2'd0;
	localparam logic [1:0] LC_INIT = 2'd0;
	localparam logic [1:0] GC_INIT = 2'd1;
	localparam logic [1:0] CH_INIT = 2'd2;

	function automatic logic [1:0] sat_move(input logic [1:0] c, input logic up);
		logic [1:0] r;
		r = c;
		if (up) begin
			if (c != CTR_MAX) r = c + 2'd1;
		end else begin
			if (c != CTR_MIN) r = c - 2'd1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/tbp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tbp_in_if: branch request channel
// valid/ready channel carrying opcode, pc and outcome.
// ---------------------------------------------------------------------------
interface tbp_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] pc;
	logic        outcome;

	modport source (output valid, output opcode, output pc, output outcome, input ready);
	modport sink (input valid, input opcode, input pc, input outcome, output ready);
	modport monitor (input valid, input opcode, input pc, input outcome, input ready);
endinterface
`default_nettype wire

// File: rtl/tbp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tbp_out_if: prediction result channel
// valid/ready channel carrying the chosen and component guesses.
// ---------------------------------------------------------------------------
interface tbp_out_if;
	logic valid;
	logic ready;
	logic prediction;
	logic local_guess;
	logic global_guess;
	logic chose_global;

	modport source (output valid, output prediction, output local_guess,
		output global_guess, output chose_global, input ready);
	modport sink (input valid, input prediction, input local_guess,
		input global_guess, input chose_global, output ready);
	modport monitor (input valid, input prediction, input local_guess,
		input global_guess, input chose_global, input ready);
endinterface
`default_nettype wire

// File: rtl/tbp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tbp_front: request intake
// Accepts request words, decodes them into train/outcome/table index and
// holds them in a two-entry queue in front of the table engine.
// ---------------------------------------------------------------------------
module tbp_front
	import tbp_pkg::*;
#(
	parameter int PC_INDEX_BITS = 10
) (
	input  wire                      clk,
	input  wire                      arst_n,
	tbp_in_if.sink                   req,
	input  wire                      clearing,
	output logic                     cmd_valid,
	input  wire                      cmd_ready,
	output logic                     cmd_train,
	output logic                     cmd_taken,
	output logic [PC_INDEX_BITS-1:0] cmd_pidx
);

	logic                     q_train_q [2];
	logic                     q_taken_q [2];
	logic [PC_INDEX_BITS-1:0] q_pidx_q  [2];
	logic                     wr_ptr_q;
	logic                     rd_ptr_q;
	logic [1:0]               count_q;
	logic                     push;
	logic                     pop;

	// hold off new words while the tables are being initialized or the queue is full
	assign req.ready = !clearing && (count_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;

	assign cmd_train = q_train_q[rd_ptr_q];
	assign cmd_taken = q_taken_q[rd_ptr_q];
	assign cmd_pidx  = q_pidx_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_train_q[wr_ptr_q] <= (tbp_op_t'(req.opcode) == OP_TRAIN);
			q_taken_q[wr_ptr_q] <= req.outcome;
			q_pidx_q[wr_ptr_q]  <= req.pc[PC_INDEX_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

// File: rtl/tbp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tbp_back: table engine
// Owns the history and counter tables, looks up the guesses, writes back
// trained values and drives the result register.
// ---------------------------------------------------------------------------
module tbp_back
	import tbp_pkg::*;
#(
	parameter int GHIST_BITS    = 12,
	parameter int LHIST_BITS    = 10,
	parameter int PC_INDEX_BITS = 10
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cmd_valid,
	output logic                     cmd_ready,
	input  wire                      cmd_train,
	input  wire                      cmd_taken,
	input  wire [PC_INDEX_BITS-1:0]  cmd_pidx,
	output logic                     clearing,
	tbp_out_if.source                rsp
);

	localparam int MAX_LP   = (LHIST_BITS > PC_INDEX_BITS) ? LHIST_BITS : PC_INDEX_BITS;
	localparam int CLR_BITS = (GHIST_BITS > MAX_LP) ? GHIST_BITS : MAX_LP;

	logic [LHIST_BITS-1:0] lht_mem [2**PC_INDEX_BITS];
	logic [1:0]            lc_mem  [2**LHIST_BITS];
	logic [1:0]            gc_mem  [2**GHIST_BITS];
	logic [1:0]            ch_mem  [2**GHIST_BITS];

	tbp_state_t              state_q, state_d;
	logic [CLR_BITS-1:0]     clr_cnt_q;
	logic [GHIST_BITS-1:0]   ghist_q;
	logic                    train_q;
	logic                    taken_q;
	logic [PC_INDEX_BITS-1:0] pidx_q;
	logic [LHIST_BITS-1:0]   lht_rdata_q;
	logic [1:0]              lc_rdata_q;
	logic [1:0]              gc_rdata_q;
	logic [1:0]              ch_rdata_q;
	logic                    rsp_valid_q;
	tbp_result_t             rsp_q;

	logic        out_free;
	logic        clear_we;
	logic        rd_first;
	logic        rd_second;
	logic        commit;
	logic        wr_en;
	logic        gok;
	logic        lok;
	logic [1:0]  ch_new;
	tbp_result_t res;

	logic [PC_INDEX_BITS-1:0] lht_waddr;
	logic [LHIST_BITS-1:0]    lht_wdata;
	logic [LHIST_BITS-1:0]    lc_waddr;
	logic [1:0]               lc_wdata;
	logic [GHIST_BITS-1:0]    g_waddr;
	logic [1:0]               gc_wdata;
	logic [1:0]               ch_wdata;

	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:   if (clr_cnt_q == {CLR_BITS{1'b1}}) state_d = ST_FETCH;
			ST_FETCH:   if (cmd_valid) state_d = ST_INDEX;
			ST_INDEX:   state_d = ST_RESOLVE;
			ST_RESOLVE: if (out_free) state_d = ST_FETCH;
			default:    state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		clear_we  = 1'b0;
		cmd_ready = 1'b0;
		rd_first  = 1'b0;
		rd_second = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ST_CLEAR: clear_we = 1'b1;
			ST_FETCH: begin
				cmd_ready = 1'b1;
				rd_first  = cmd_valid;
			end
			ST_INDEX:   rd_second = 1'b1;
			ST_RESOLVE: commit    = out_free;
			default: begin
				clear_we = 1'b0;
			end
		endcase
	end

	assign clearing = (state_q == ST_CLEAR);

	// guesses as they stand before this word's update
	always_comb begin
		res.local_guess  = lc_rdata_q[1];
		res.global_guess = gc_rdata_q[1];
		res.chose_global = ch_rdata_q[1];
		res.prediction   = ch_rdata_q[1] ? gc_rdata_q[1] : lc_rdata_q[1];
	end

	assign gok = (res.global_guess == taken_q);
	assign lok = (res.local_guess == taken_q);

	// move the chooser only when exactly one side was right
	always_comb begin
		ch_new = ch_rdata_q;
		if (gok && !lok) ch_new = sat_move(ch_rdata_q, 1'b1);
		else if (!gok && lok) ch_new = sat_move(ch_rdata_q, 1'b0);
	end

	assign wr_en     = clear_we || (commit && train_q);
	assign lht_waddr = clear_we ? clr_cnt_q[PC_INDEX_BITS-1:0] : pidx_q;
	assign lht_wdata = clear_we ? LHIST_BITS'(1) : LHIST_BITS'({lht_rdata_q, taken_q});
	assign lc_waddr  = clear_we ? clr_cnt_q[LHIST_BITS-1:0] : lht_rdata_q;
	assign lc_wdata  = clear_we ? LC_INIT : sat_move(lc_rdata_q, taken_q);
	assign g_waddr   = clear_we ? clr_cnt_q[GHIST_BITS-1:0] : ghist_q;
	assign gc_wdata  = clear_we ? GC_INIT : sat_move(gc_rdata_q, taken_q);
	assign ch_wdata  = clear_we ? CH_INIT : ch_new;

	always_ff @(posedge clk) begin
		if (wr_en) lht_mem[lht_waddr] <= lht_wdata;
		if (rd_first) lht_rdata_q <= lht_mem[cmd_pidx];
	end

	always_ff @(posedge clk) begin
		if (wr_en) lc_mem[lc_waddr] <= lc_wdata;
		if (rd_second) lc_rdata_q <= lc_mem[lht_rdata_q];
	end

	always_ff @(posedge clk) begin
		if (wr_en) gc_mem[g_waddr] <= gc_wdata;
		if (rd_first) gc_rdata_q <= gc_mem[ghist_q];
	end

	always_ff @(posedge clk) begin
		if (wr_en) ch_mem[g_waddr] <= ch_wdata;
		if (rd_first) ch_rdata_q <= ch_mem[ghist_q];
	end

	always_ff @(posedge clk) begin
		if (rd_first) begin
			train_q <= cmd_train;
			taken_q <= cmd_taken;
			pidx_q  <= cmd_pidx;
		end
		if (commit) rsp_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			ghist_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clear_we) clr_cnt_q <= clr_cnt_q + CLR_BITS'(1);
			if (commit && train_q) ghist_q <= GHIST_BITS'({ghist_q, taken_q});
			if (commit) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.prediction   = rsp_q.prediction;
	assign rsp.local_guess  = rsp_q.local_guess;
	assign rsp.global_guess = rsp_q.global_guess;
	assign rsp.chose_global = rsp_q.chose_global;

endmodule
`default_nettype wire

// File: rtl/tournament_branch_predictor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A word passes through the intake queue, the local history, global counter and
// chooser reads, the dependent local counter read, then the table writeback, which
// waits while a result is held; the engine takes no new word before then, while the
// queue holds up to two words. Reset: asynchronous, active low; afterwards the engine
// initializes all tables one entry per cycle over 2**max(GHIST_BITS, LHIST_BITS,
// PC_INDEX_BITS) entries (4096 by default), with req.ready held low until it is done.
// ---------------------------------------------------------------------------
// tournament_branch_predictor_core: local/global tournament predictor
// Request intake and queue feeding the table engine and result register.
// ---------------------------------------------------------------------------
module tournament_branch_predictor_core
	import tbp_pkg::*;
#(
	parameter int GHIST_BITS    = 12,
	parameter int LHIST_BITS    = 10,
	parameter int PC_INDEX_BITS = 10
) (
	input  wire       clk,
	input  wire       arst_n,
	tbp_in_if.sink    req,
	tbp_out_if.source rsp
);

	logic                     cmd_valid;
	logic                     cmd_ready;
	logic                     cmd_train;
	logic                     cmd_taken;
	logic [PC_INDEX_BITS-1:0] cmd_pidx;
	logic                     clearing;

	tbp_front #(
		.PC_INDEX_BITS(PC_INDEX_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.clearing  (clearing),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_train (cmd_train),
		.cmd_taken (cmd_taken),
		.cmd_pidx  (cmd_pidx)
	);

	tbp_back #(
		.GHIST_BITS   (GHIST_BITS),
		.LHIST_BITS   (LHIST_BITS),
		.PC_INDEX_BITS(PC_INDEX_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_train (cmd_train),
		.cmd_taken (cmd_taken),
		.cmd_pidx  (cmd_pidx),
		.clearing  (clearing),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// File: rtl/tbp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tbp_checker: port-level checks of the predictor
// Tracks words in flight and checks result validity, stalled results and reset behavior.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tbp_checker (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       req_valid,
	input  wire       req_ready,
	input  wire       rsp_valid,
	input  wire       rsp_ready,
	input  wire [3:0] rsp_word
);

	logic [2:0] pend_q;
	logic       acc;
	logic       del;

	assign acc = req_valid && req_ready;
	assign del = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else begin
			if (acc && !del) pend_q <= pend_q + 3'd1;
			else if (del && !acc) pend_q <= pend_q - 3'd1;
		end
	end

	`TBP_ASSERT(a_rsp_has_word, rsp_valid |-> (pend_q != 3'd0), "result without pending word")
	`TBP_ASSERT(a_pend_bound, pend_q <= 3'd4, "more words in flight than the block holds")
	`TBP_ASSERT_NR(a_clear_blocks, $rose(arst_n) |-> !req_ready, "ready during table init")
	`TBP_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_word)), "stalled result changed")

endmodule

bind tournament_branch_predictor_core tbp_checker u_tbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_word  ({rsp.prediction, rsp.local_guess, rsp.global_guess, rsp.chose_global})
);
`default_nettype wire
